FILE: design/integer_stack_machine_alu_macros.svh
// Assertion macros shared by the stack ALU modules.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef INTEGER_STACK_MACHINE_ALU_MACROS_SVH
`define INTEGER_STACK_MACHINE_ALU_MACROS_SVH

// same-cycle implication, disabled in reset
`define ISMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ISMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/isma_pkg.sv
// Types, opcodes and error codes of the integer stack ALU.
// No dependencies; imported by every module of the block except isma_div.
`default_nettype none

package isma_pkg;

    localparam logic [3:0] OP_PUSH = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_MOD  = 4'd5;
    localparam logic [3:0] OP_EQ   = 4'd6;
    localparam logic [3:0] OP_NE   = 4'd7;
    localparam logic [3:0] OP_GT   = 4'd8;
    localparam logic [3:0] OP_GE   = 4'd9;
    localparam logic [3:0] OP_LT   = 4'd10;
    localparam logic [3:0] OP_LE   = 4'd11;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_UNDER   = 2'd1;
    localparam logic [1:0] ERR_OVER    = 2'd2;
    localparam logic [1:0] ERR_DIVZERO = 2'd3;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic [6:0]         depth;
        logic [1:0]         error;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       push;
        logic       set_err;
        logic [1:0] err;
        logic       alu_commit;
        logic       div_start;
        logic       div_commit;
        logic       out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic is_binop;
        logic is_divmod;
        logic full;
        logic lt2;
        logic b_zero;
        logic div_done;
    } t_stat;

endpackage

`default_nettype wire

FILE: design/isma_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Uses isma_pkg-free plain vectors; instanced by isma_dpath.
`default_nettype none

`include "integer_stack_machine_alu_macros.svh"

module isma_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_dividend,
    input  wire logic signed [31:0] i_divisor,
    output logic                    o_done,
    output logic signed [31:0]      o_quo,
    output logic signed [31:0]      o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic        r_neg_q;
    logic        r_neg_r;

    logic [32:0] w_trial;
    logic [31:0] w_abs_a;
    logic [31:0] w_abs_b;

    assign w_abs_a = i_dividend[31] ? 32'(-i_dividend) : i_dividend;
    assign w_abs_b = i_divisor[31]  ? 32'(-i_divisor)  : i_divisor;
    // partial remainder stays below the divisor, so its top bit is clear
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= 5'd31;
            r_quo   <= w_abs_a;
            r_rem   <= '0;
            r_dvs   <= w_abs_b;
            r_neg_q <= i_dividend[31] ^ i_divisor[31];
            r_neg_r <= i_dividend[31];
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg_q ? 32'(-r_quo) : r_quo;
    assign o_rem  = r_neg_r ? 32'(-r_rem) : r_rem;

    `ISMA_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")

endmodule

`default_nettype wire

FILE: design/isma_dpath.sv
// Datapath: top-of-stack register, stack memory, ALU, divider, output word.
// Depends on isma_pkg and isma_div; driven by commands from isma_ctrl.
`default_nettype none

`include "integer_stack_machine_alu_macros.svh"

module isma_dpath #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire isma_pkg::t_in_word i_in_data,
    input  wire isma_pkg::t_cmd     i_cmd,
    output isma_pkg::t_stat         o_stat,
    output isma_pkg::t_out_word     o_out_data
);

    import isma_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // entries below the top live in the memory; the top lives in r_top
    logic [31:0] mem [STACK_DEPTH];

    logic [3:0]         r_func;
    logic signed [31:0] r_pv;
    logic [DW-1:0]      r_depth;
    logic signed [31:0] r_top;
    logic signed [31:0] r_rd_data;
    logic [1:0]         r_err;
    t_out_word          r_out;

    logic [DW-1:0]      w_dm1;
    logic [DW-1:0]      w_dm2;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;
    logic signed [31:0] w_alu;
    logic [DW+6:0]      w_dext;
    t_out_word          w_out;
    logic               w_div_done;
    logic signed [31:0] w_quo;
    logic signed [31:0] w_rem;

    assign w_dm1     = r_depth - 1'b1;
    assign w_dm2     = r_depth - 2'd2;
    assign w_wr_addr = w_dm1[AW-1:0];
    assign w_rd_addr = w_dm2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_depth != '0) begin
            mem[w_wr_addr] <= r_top;
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_in_data.func;
            r_pv   <= i_in_data.push_value;
        end
        if (i_cmd.set_err) begin
            r_err <= i_cmd.err;
        end
        if (i_cmd.out_load) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + 1'b1;
        end else if (i_cmd.alu_commit || i_cmd.div_commit) begin
            r_depth <= w_dm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= r_pv;
        end else if (i_cmd.alu_commit) begin
            r_top <= w_alu;
        end else if (i_cmd.div_commit) begin
            r_top <= (r_func == OP_DIV) ? w_quo : w_rem;
        end
    end

    // a = second from top (memory), b = top
    always_comb begin
        case (r_func)
            OP_ADD:  w_alu = r_rd_data + r_top;
            OP_SUB:  w_alu = r_rd_data - r_top;
            OP_MUL:  w_alu = r_rd_data * r_top;
            OP_EQ:   w_alu = {31'd0, r_rd_data == r_top};
            OP_NE:   w_alu = {31'd0, r_rd_data != r_top};
            OP_GT:   w_alu = {31'd0, r_rd_data >  r_top};
            OP_GE:   w_alu = {31'd0, r_rd_data >= r_top};
            OP_LT:   w_alu = {31'd0, r_rd_data <  r_top};
            OP_LE:   w_alu = {31'd0, r_rd_data <= r_top};
            default: w_alu = '0;
        endcase
    end

    isma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rd_data),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    assign o_stat.is_push   = (r_func == OP_PUSH);
    assign o_stat.is_binop  = (r_func >= OP_ADD) && (r_func <= OP_LE);
    assign o_stat.is_divmod = (r_func == OP_DIV) || (r_func == OP_MOD);
    assign o_stat.full      = (r_depth == DW'(STACK_DEPTH));
    assign o_stat.lt2       = (r_depth < DW'(2));
    assign o_stat.b_zero    = (r_top == '0);
    assign o_stat.div_done  = w_div_done;

    // reported depth is the low seven bits of the count
    assign w_dext          = {7'd0, r_depth};
    assign w_out.top_value = (r_depth == '0) ? '0 : r_top;
    assign w_out.depth     = w_dext[6:0];
    assign w_out.error     = r_err;

    assign o_out_data = r_out;

    `ISMA_ASSERT_IMP(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(STACK_DEPTH), "stack depth beyond capacity")
    `ISMA_ASSERT_NXT(a_push_incr, i_clk, i_rst_n, i_cmd.push, r_depth == DW'($past(r_depth) + 1'b1), "push did not grow stack by one")

endmodule

`default_nettype wire

FILE: design/isma_ctrl.sv
// Controller state machine: sequences decode, execute, divide and write-back.
// Depends on isma_pkg; commands isma_dpath and owns both handshakes.
`default_nettype none

`include "integer_stack_machine_alu_macros.svh"

module isma_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire isma_pkg::t_stat i_stat,
    output isma_pkg::t_cmd       o_cmd
);

    import isma_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                w_cmd.set_err = 1'b1;
                w_cmd.err     = ERR_OK;
                n_state       = ST_WB;
                if (i_stat.is_push) begin
                    if (i_stat.full) begin
                        w_cmd.err = ERR_OVER;
                    end else begin
                        w_cmd.push = 1'b1;
                    end
                end else if (i_stat.is_binop) begin
                    // underflow wins over divide by zero
                    if (i_stat.lt2) begin
                        w_cmd.err = ERR_UNDER;
                    end else if (i_stat.is_divmod && i_stat.b_zero) begin
                        w_cmd.err = ERR_DIVZERO;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (i_stat.is_divmod) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    w_cmd.alu_commit = 1'b1;
                    n_state          = ST_WB;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    w_cmd.div_commit = 1'b1;
                    n_state          = ST_WB;
                end
            end
            ST_WB: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    `ISMA_ASSERT_NXT(a_accept_decode, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == ST_DECODE, "accepted word not decoded")
    `ISMA_ASSERT_NXT(a_div_hold, i_clk, i_rst_n, r_state == ST_DIV && !i_stat.div_done, r_state == ST_DIV, "left divide before quotient ready")

endmodule

`default_nettype wire

FILE: design/integer_stack_machine_alu.sv
// Top level of the integer stack ALU: controller plus datapath.
// Depends on isma_pkg, isma_ctrl, isma_dpath (which holds isma_div).
//
//   channel | valid       | stall        | word
//   in      | i_in_valid  | o_in_stall   | i_in_data  (func, push_value)
//   out     | o_out_valid | i_out_stall  | o_out_data (top_value, depth, error)
//
// One word in the datapath at a time, plus one held in the output register.
// Push, unused opcodes and errors pass decode and write-back; other binary ops
// add execute; divide and modulo then wait on the one-bit-per-cycle divider.
// The second-from-top entry comes from a registered read of the stack memory.
// i_rst_n (synchronous) empties the stack; memory contents are not cleared.
// A word waiting in the output register is held while i_out_stall is high;
// the next word is still taken, and finishes once that register frees.
`default_nettype none

module integer_stack_machine_alu #(
    parameter int unsigned STACK_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire isma_pkg::t_in_word  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output isma_pkg::t_out_word      o_out_data
);

    import isma_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    isma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    isma_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
